// ===== src/tcp_server_session_engine_core_assert.svh =====
// Assertion macros for the session engine checker
`ifndef TCP_SERVER_SESSION_ENGINE_CORE_ASSERT_SVH
`define TCP_SERVER_SESSION_ENGINE_CORE_ASSERT_SVH
// implication checked every edge outside reset
`define SSE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lbl failed");
// next-cycle implication
`define SSE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lbl failed");
`endif

// ===== src/tsse_pkg.sv =====
// Shared types and constants of the session engine
`default_nettype none
package tsse_pkg;
   localparam logic [1:0] CMD_OPEN = 2'd0;
   localparam logic [1:0] CMD_SEG  = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;
   localparam logic [1:0] KIND_SEG  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;
   localparam logic [1:0] KIND_DONE = 2'd3;
   localparam logic [2:0] ST_CLOSED  = 3'd0;
   localparam logic [2:0] ST_LISTEN  = 3'd1;
   localparam logic [2:0] ST_SYNRCV  = 3'd2;
   localparam logic [2:0] ST_ESTAB   = 3'd3;
   localparam logic [2:0] ST_LASTACK = 3'd4;
   localparam logic [5:0] F_FIN = 6'd1;
   localparam logic [5:0] F_SYN = 6'd2;
   localparam logic [5:0] F_RST = 6'd4;
   localparam logic [5:0] F_ACK = 6'd16;
   localparam logic [1:0] REG_ISN = 2'd0;
   localparam logic [1:0] REG_WIN = 2'd1;
   localparam logic [1:0] REG_IDLE = 2'd2;
   localparam logic [1:0] REG_BUF = 2'd3;
   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [31:0] seq_in;
      logic [31:0] ack_in;
      logic [5:0]  flags_in;
      logic [15:0] window_in;
      logic [15:0] data_len_in;
      logic [6:0]  header_len;
   } req_type;
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  session;
      logic [5:0]  flags_out;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic [15:0] window_out;
      logic [31:0] remote_ip;
      logic [15:0] remote_port;
      logic [15:0] local_port;
      logic [10:0] data_offset;
      logic [10:0] data_len_out;
      logic        last_item;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/tcp_server_session_engine_core.sv =====
// Top level of the server-side TCP session engine
// Requests are handled one at a time; the next is taken only once the last
// result beat of the one before has left. The table walk covers one entry
// a cycle; a segment that falls back to a listener walks the table three
// times. Results leave at one beat per cycle unless rsp_stall holds them.
// Synchronous active-high reset closes all sessions and restores registers.
`default_nettype none
module tcp_server_session_engine_core import tsse_pkg::*; #(
   parameter int SESSIONS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [31:0] req_seq_in,
   input  wire logic [31:0] req_ack_in,
   input  wire logic [5:0]  req_flags_in,
   input  wire logic [15:0] req_window_in,
   input  wire logic [15:0] req_data_len_in,
   input  wire logic [6:0]  req_header_len,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_session,
   output logic [5:0]       rsp_flags_out,
   output logic [31:0]      rsp_seq_out,
   output logic [31:0]      rsp_ack_out,
   output logic [15:0]      rsp_window_out,
   output logic [31:0]      rsp_remote_ip,
   output logic [15:0]      rsp_remote_port,
   output logic [15:0]      rsp_local_port,
   output logic [10:0]      rsp_data_offset,
   output logic [10:0]      rsp_data_len_out,
   output logic             rsp_last_item
);
   req_type in_item, q_item;
   rsp_type r;
   logic    q_valid, q_take;

   assign in_item = '{req_command, req_src_ip, req_src_port, req_dst_port, req_seq_in,
      req_ack_in, req_flags_in, req_window_in, req_data_len_in, req_header_len};

   tsse_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_item,
      .out_valid(q_valid), .out_take(q_take), .out_item(q_item)
   );

   tsse_back #(.SESSIONS(SESSIONS)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_take(q_take), .cmd_item(q_item),
      .cfg_we(csr_we), .cfg_idx(csr_index), .cfg_data(csr_data),
      .rsp_valid, .rsp_stall, .rsp_item(r)
   );

   assign rsp_kind = r.kind;
   assign rsp_session = r.session;
   assign rsp_flags_out = r.flags_out;
   assign rsp_seq_out = r.seq_out;
   assign rsp_ack_out = r.ack_out;
   assign rsp_window_out = r.window_out;
   assign rsp_remote_ip = r.remote_ip;
   assign rsp_remote_port = r.remote_port;
   assign rsp_local_port = r.local_port;
   assign rsp_data_offset = r.data_offset;
   assign rsp_data_len_out = r.data_len_out;
   assign rsp_last_item = r.last_item;
endmodule
`default_nettype wire

// ===== src/tsse_front.sv =====
// Front end: two-entry request queue between input port and session engine
`default_nettype none
module tsse_front import tsse_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire req_type in_item,
   output logic         out_valid,
   input  wire logic    out_take,
   output req_type      out_item
);
   req_type    mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_item  = mem_ff[rp_ff];

   // track fill level
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ===== src/tsse_back.sv =====
// Back end: session table, lookup walk, segment handling and result beats
`default_nettype none
module tsse_back import tsse_pkg::*; #(
   parameter int SESSIONS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_take,
   input  wire req_type     cmd_item,
   input  wire logic        cfg_we,
   input  wire logic [1:0]  cfg_idx,
   input  wire logic [31:0] cfg_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_item
);
   localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int CW = $clog2(SESSIONS + 1);
   localparam logic [CW-1:0] LAST = CW'(SESSIONS - 1);

   localparam logic [3:0] P_IDLE = 4'd0, P_FIND = 4'd1, P_LSN = 4'd2, P_FREE = 4'd3,
      P_EXEC = 4'd4, P_EMIT = 4'd5, P_TICK = 4'd6, P_CLIP = 4'd7, P_DATA = 4'd8;

   logic [31:0] isn_ff;
   logic [15:0] lwin_ff;
   logic [7:0]  idle_ff;
   logic [10:0] bsz_ff;

   logic [2:0]  st_ff [SESSIONS];
   logic [15:0] lp_ff [SESSIONS];
   logic [15:0] rp_ff [SESSIONS];
   logic [31:0] ip_ff [SESSIONS];
   logic [31:0] sq_ff [SESSIONS];
   logic [31:0] ak_ff [SESSIONS];
   logic [15:0] rw_ff [SESSIONS];
   logic [7:0]  to_ff [SESSIONS];
   logic [31:0] la_ff [SESSIONS];
   logic        ap_ff [SESSIONS];

   logic [3:0]    ph_ff;
   logic [CW-1:0] k_ff;
   logic [IW-1:0] s_ff, fr_ff;
   logic          frf_ff;
   req_type       r_ff;
   logic [16:0]   off_ff, len_ff;
   rsp_type       q_ff [3];
   logic [1:0]    qn_ff, qr_ff;

   logic [IW-1:0] k;
   assign k = k_ff[IW-1:0];
   assign cmd_take = (ph_ff == P_IDLE) && (qn_ff == 2'd0) && cmd_valid;
   assign rsp_valid = (ph_ff == P_EMIT);
   assign rsp_item  = q_ff[qr_ff];

   function automatic rsp_type mk(input logic [1:0] kd, input logic [IW-1:0] s);
      rsp_type r;
      r = '0;
      r.kind = kd;
      r.session = 3'(s);
      return r;
   endfunction

   function automatic rsp_type fin(input logic [1:0] kd, input logic [IW-1:0] s);
      rsp_type r;
      r = mk(kd, s);
      r.last_item = 1'b1;
      return r;
   endfunction

   // segment descriptor built from a session's current fields
   function automatic rsp_type sg(input logic [IW-1:0] s, input logic [5:0] f,
         input logic [31:0] sq, input logic [31:0] ak, input logic [15:0] w,
         input logic [31:0] ip, input logic [15:0] rp, input logic [15:0] lp);
      rsp_type r;
      r = mk(KIND_SEG, s);
      r.flags_out = f;
      r.seq_out = sq;
      r.ack_out = ak;
      r.window_out = w;
      r.remote_ip = ip;
      r.remote_port = rp;
      r.local_port = lp;
      return r;
   endfunction

   logic [31:0] dup;
   logic [31:0] ssq, sak;
   logic [16:0] o1, lsum;
   assign ssq = sq_ff[s_ff];
   assign sak = ak_ff[s_ff];
   assign dup = sak - r_ff.seq_in;
   assign o1 = (off_ff > {6'd0, bsz_ff}) ? {6'd0, bsz_ff} : off_ff;
   assign lsum = o1 + len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         isn_ff <= 32'd1234;
         lwin_ff <= 16'd8192;
         idle_ff <= 8'd10;
         bsz_ff <= 11'd1500;
         ph_ff <= P_IDLE;
         qn_ff <= 2'd0;
         qr_ff <= 2'd0;
         for (int i = 0; i < SESSIONS; i++) begin
            st_ff[i] <= ST_CLOSED; lp_ff[i] <= '0; rp_ff[i] <= '0; ip_ff[i] <= '0;
            sq_ff[i] <= '0; ak_ff[i] <= '0; rw_ff[i] <= '0; to_ff[i] <= '0;
            la_ff[i] <= '0; ap_ff[i] <= 1'b0;
         end
      end else begin
         // configuration writes
         if (cfg_we) begin
            case (cfg_idx)
               REG_ISN: isn_ff <= cfg_data;
               REG_WIN: lwin_ff <= cfg_data[15:0];
               REG_IDLE: idle_ff <= cfg_data[7:0];
               REG_BUF: bsz_ff <= cfg_data[10:0];
               default: ;
            endcase
         end
         case (ph_ff)
            P_IDLE: begin
               if (cmd_take) begin
                  r_ff <= cmd_item;
                  k_ff <= '0;
                  frf_ff <= 1'b0;
                  fr_ff <= '0;
                  qr_ff <= 2'd0;
                  case (cmd_item.command)
                     CMD_OPEN: ph_ff <= P_FREE;
                     CMD_SEG: ph_ff <= P_FIND;
                     CMD_TICK: ph_ff <= P_TICK;
                     default: begin
                        q_ff[0] <= fin(KIND_DONE, '0);
                        qn_ff <= 2'd1;
                        ph_ff <= P_EMIT;
                     end
                  endcase
               end
            end
            // walk for a free entry, then open the listener; a segment then
            // goes on with the listener it matched
            P_FREE: begin
               if (!frf_ff && st_ff[k] == ST_CLOSED) begin
                  frf_ff <= 1'b1; fr_ff <= k;
               end
               if (k_ff == LAST) begin
                  logic [IW-1:0] s;
                  s = (!frf_ff && st_ff[k] == ST_CLOSED) ? k : fr_ff;
                  lp_ff[s] <= r_ff.dst_port;
                  st_ff[s] <= ST_LISTEN;
                  rw_ff[s] <= lwin_ff;
                  to_ff[s] <= idle_ff;
                  if (r_ff.command == CMD_SEG) begin
                     ph_ff <= P_EXEC;
                  end else begin
                     q_ff[0] <= fin(KIND_DONE, s);
                     qn_ff <= 2'd1;
                     ph_ff <= P_EMIT;
                  end
               end else k_ff <= k_ff + 1'b1;
            end
            // walk for an exact session match
            P_FIND: begin
               if (st_ff[k] != ST_CLOSED && lp_ff[k] == r_ff.dst_port &&
                   rp_ff[k] == r_ff.src_port && ip_ff[k] == r_ff.src_ip) begin
                  s_ff <= k; ph_ff <= P_EXEC;
               end else if (k_ff == LAST) begin
                  k_ff <= '0; ph_ff <= P_LSN;
               end else k_ff <= k_ff + 1'b1;
            end
            // walk for a listener; also note the first free entry for its clone
            P_LSN: begin
               if (!frf_ff && st_ff[k] == ST_CLOSED) begin
                  frf_ff <= 1'b1; fr_ff <= k;
               end
               if (st_ff[k] == ST_LISTEN && lp_ff[k] == r_ff.dst_port) begin
                  rp_ff[k] <= r_ff.src_port;
                  ip_ff[k] <= r_ff.src_ip;
                  s_ff <= k;
                  k_ff <= '0;
                  frf_ff <= 1'b0;
                  ph_ff <= P_FREE;
                  r_ff.command <= CMD_SEG;
               end else if (k_ff == LAST) begin
                  q_ff[0] <= fin(KIND_NONE, '0);
                  qn_ff <= 2'd1;
                  ph_ff <= P_EMIT;
               end else k_ff <= k_ff + 1'b1;
            end
            P_EXEC: begin
               logic [IW-1:0] s;
               logic [5:0] f;
               s = s_ff;
               f = r_ff.flags_in;
               to_ff[s] <= idle_ff;
               ph_ff <= P_EMIT;
               if ((f & F_RST) != 6'd0) begin
                  st_ff[s] <= ST_CLOSED;
                  q_ff[0] <= fin(KIND_DONE, s); qn_ff <= 2'd1;
               end else begin
                  case (st_ff[s])
                     ST_LISTEN: begin
                        if (f == F_SYN) begin
                           st_ff[s] <= ST_SYNRCV;
                           sq_ff[s] <= isn_ff + 32'd1;
                           ak_ff[s] <= r_ff.seq_in + 32'd1;
                           rw_ff[s] <= r_ff.window_in;
                           q_ff[0] <= sg(s, F_SYN | F_ACK, isn_ff, r_ff.seq_in + 32'd1,
                              lwin_ff, ip_ff[s], rp_ff[s], lp_ff[s]);
                           q_ff[1] <= fin(KIND_DONE, s); qn_ff <= 2'd2;
                        end else begin
                           q_ff[0] <= fin(KIND_DONE, s); qn_ff <= 2'd1;
                        end
                     end
                     ST_SYNRCV: begin
                        if (f == F_ACK && ssq == r_ff.ack_in) begin
                           st_ff[s] <= ST_ESTAB; ap_ff[s] <= 1'b1;
                        end
                        q_ff[0] <= fin(KIND_DONE, s); qn_ff <= 2'd1;
                     end
                     ST_ESTAB: begin
                        if ((f & F_FIN) != 6'd0) begin
                           logic [31:0] na;
                           na = r_ff.seq_in + {16'd0, r_ff.data_len_in} + 32'd1;
                           ak_ff[s] <= na;
                           sq_ff[s] <= ssq + 32'd1;
                           st_ff[s] <= ST_CLOSED;
                           q_ff[0] <= sg(s, F_ACK, ssq, na, lwin_ff,
                              ip_ff[s], rp_ff[s], lp_ff[s]);
                           q_ff[1] <= sg(s, F_FIN | F_ACK, ssq, na, lwin_ff,
                              ip_ff[s], rp_ff[s], lp_ff[s]);
                           q_ff[2] <= fin(KIND_DONE, s); qn_ff <= 2'd3;
                        end else begin
                           logic [31:0] nsq;
                           nsq = ssq;
                           if ((f & F_ACK) != 6'd0) begin
                              la_ff[s] <= r_ff.ack_in;
                              nsq = r_ff.ack_in;
                              sq_ff[s] <= nsq;
                           end
                           off_ff <= {10'd0, r_ff.header_len};
                           len_ff <= {1'b0, r_ff.data_len_in};
                           if (r_ff.seq_in != sak) begin
                              if (r_ff.seq_in < sak &&
                                  dup < {16'd0, r_ff.data_len_in}) begin
                                 off_ff <= {10'd0, r_ff.header_len} + dup[16:0];
                                 len_ff <= {1'b0, r_ff.data_len_in} - dup[16:0];
                                 ph_ff <= P_CLIP;
                              end else begin
                                 q_ff[0] <= sg(s, F_ACK, nsq, sak, lwin_ff,
                                    ip_ff[s], rp_ff[s], lp_ff[s]);
                                 q_ff[1] <= fin(KIND_DONE, s); qn_ff <= 2'd2;
                              end
                           end else ph_ff <= P_CLIP;
                        end
                     end
                     ST_LASTACK: begin
                        if (r_ff.seq_in == ssq + 32'd1) begin
                           st_ff[s] <= ST_CLOSED;
                           q_ff[0] <= fin(KIND_DONE, s); qn_ff <= 2'd1;
                        end else begin
                           sq_ff[s] <= ssq + 32'd1;
                           q_ff[0] <= sg(s, F_FIN | F_ACK, ssq, sak, lwin_ff,
                              ip_ff[s], rp_ff[s], lp_ff[s]);
                           q_ff[1] <= fin(KIND_DONE, s); qn_ff <= 2'd2;
                        end
                     end
                     default: begin
                        st_ff[s] <= ST_CLOSED;
                        q_ff[0] <= fin(KIND_DONE, s); qn_ff <= 2'd1;
                     end
                  endcase
               end
            end
            // clip to buffer and advance ack; P_DATA then builds the data beat
            P_CLIP: begin
               logic [16:0] l1;
               l1 = (lsum > {6'd0, bsz_ff}) ? ({6'd0, bsz_ff} - o1) : len_ff;
               ak_ff[s_ff] <= sak + {15'd0, l1};
               ap_ff[s_ff] <= 1'b1;
               off_ff <= o1;
               len_ff <= l1;
               ph_ff <= P_DATA;
            end
            P_DATA: begin
               if (len_ff != 17'd0) begin
                  rsp_type r;
                  r = mk(KIND_DATA, s_ff);
                  r.remote_ip = ip_ff[s_ff];
                  r.remote_port = rp_ff[s_ff];
                  r.local_port = lp_ff[s_ff];
                  r.data_offset = off_ff[10:0];
                  r.data_len_out = len_ff[10:0];
                  q_ff[0] <= r;
                  q_ff[1] <= fin(KIND_DONE, s_ff); qn_ff <= 2'd2;
               end else begin
                  q_ff[0] <= fin(KIND_DONE, s_ff); qn_ff <= 2'd1;
               end
               ph_ff <= P_EMIT;
            end
            // age active sessions, one per cycle
            P_TICK: begin
               if (st_ff[k] != ST_CLOSED && st_ff[k] != ST_LISTEN) begin
                  if (to_ff[k] <= 8'd1) begin
                     to_ff[k] <= 8'd0; st_ff[k] <= ST_CLOSED;
                  end else to_ff[k] <= to_ff[k] - 8'd1;
               end
               if (k_ff == LAST) begin
                  q_ff[0] <= fin(KIND_DONE, '0); qn_ff <= 2'd1; ph_ff <= P_EMIT;
               end else k_ff <= k_ff + 1'b1;
            end
            P_EMIT: begin
               if (!rsp_stall) begin
                  if (qn_ff == 2'd1) begin
                     qn_ff <= 2'd0; ph_ff <= P_IDLE;
                  end else begin
                     qn_ff <= qn_ff - 2'd1; qr_ff <= qr_ff + 2'd1;
                  end
               end
            end
            default: ph_ff <= P_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== src/tsse_checker.sv =====
// Port-level checker for the session engine, bound to the top level
`default_nettype none
`include "tcp_server_session_engine_core_assert.svh"
module tsse_checker import tsse_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [5:0] rsp_flags_out,
   input wire logic [10:0] rsp_data_len_out,
   input wire logic       rsp_last_item
);
   `SSE_ASSERT_NXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind))
   `SSE_ASSERT_IMP(a_last, rsp_valid && rsp_last_item, rsp_kind == KIND_DONE || rsp_kind == KIND_NONE)
   `SSE_ASSERT_IMP(a_data, rsp_valid && rsp_kind == KIND_DATA, rsp_data_len_out != 11'd0 && rsp_flags_out == 6'd0)
   `SSE_ASSERT_IMP(a_seg, rsp_valid && rsp_kind == KIND_SEG, !rsp_last_item && rsp_flags_out != 6'd0)
endmodule
bind tcp_server_session_engine_core tsse_checker u_chk (.*);
`default_nettype wire

// ===== sim/tcp_server_session_engine_core_tb.sv =====
// Self-checking testbench of the server-side TCP session engine
`default_nettype none
module tcp_server_session_engine_core_tb;
   import tsse_pkg::*;

   localparam int NSES = 8;
   localparam logic [1:0] CMD_BAD = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = '0;
   logic [31:0] req_src_ip = '0;
   logic [15:0] req_src_port = '0;
   logic [15:0] req_dst_port = '0;
   logic [31:0] req_seq_in = '0;
   logic [31:0] req_ack_in = '0;
   logic [5:0] req_flags_in = '0;
   logic [15:0] req_window_in = '0;
   logic [15:0] req_data_len_in = '0;
   logic [6:0] req_header_len = 7'd40;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_session;
   logic [5:0] rsp_flags_out;
   logic [31:0] rsp_seq_out;
   logic [31:0] rsp_ack_out;
   logic [15:0] rsp_window_out;
   logic [31:0] rsp_remote_ip;
   logic [15:0] rsp_remote_port;
   logic [15:0] rsp_local_port;
   logic [10:0] rsp_data_offset;
   logic [10:0] rsp_data_len_out;
   logic rsp_last_item;

   tcp_server_session_engine_core i_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // shadow copy of configuration and session table
   logic [31:0] cfg_isn;
   logic [15:0] cfg_win;
   logic [7:0]  cfg_idle;
   logic [10:0] cfg_buf;
   logic [2:0]  t_state [NSES];
   logic [15:0] t_lport [NSES];
   logic [15:0] t_rport [NSES];
   logic [31:0] t_rip   [NSES];
   logic [31:0] t_sseq  [NSES];
   logic [31:0] t_rack  [NSES];
   logic [7:0]  t_tmo   [NSES];

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   bit quiet = 1'b0;
   bit hold_go = 1'b0;
   bit rx_hold = 1'b0;
   int req_gap = 0;
   int rsp_gap = 0;

   function automatic rsp_type blank_rsp(logic [1:0] k, int s);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.session = s[2:0];
      return r;
   endfunction

   function automatic void push_segment(int s, logic [5:0] f);
      rsp_type r;
      r = blank_rsp(KIND_SEG, s);
      r.flags_out = f;
      r.seq_out = t_sseq[s];
      r.ack_out = t_rack[s];
      r.window_out = cfg_win;
      r.remote_ip = t_rip[s];
      r.remote_port = t_rport[s];
      r.local_port = t_lport[s];
      expected_rsps.push_back(r);
      if (f & (F_FIN | F_SYN)) t_sseq[s] = t_sseq[s] + 1;
   endfunction

   function automatic void push_done(logic [1:0] k, int s);
      rsp_type r;
      r = blank_rsp(k, s);
      r.last_item = 1'b1;
      expected_rsps.push_back(r);
   endfunction

   function automatic int take_listener(logic [15:0] port);
      int s;
      s = 0;
      for (int k = 0; k < NSES; k++)
         if (t_state[k] == ST_CLOSED) begin
            s = k;
            break;
         end
      t_lport[s] = port;
      t_state[s] = ST_LISTEN;
      t_tmo[s] = cfg_idle;
      return s;
   endfunction

   // work out every result beat that one request causes
   function automatic void predict_session(req_type q);
      int s;
      bit hit;
      logic [16:0] off;
      logic [16:0] len;
      logic [31:0] dup;
      rsp_type r;
      hit = 1'b0;
      s = 0;
      off = {10'd0, q.header_len};
      len = {1'b0, q.data_len_in};
      if (q.command == CMD_OPEN) begin
         push_done(KIND_DONE, take_listener(q.dst_port));
         return;
      end
      if (q.command == CMD_TICK) begin
         for (int k = 0; k < NSES; k++)
            if (t_state[k] != ST_CLOSED && t_state[k] != ST_LISTEN) begin
               if (t_tmo[k] != 0) t_tmo[k]--;
               if (t_tmo[k] == 0) t_state[k] = ST_CLOSED;
            end
         push_done(KIND_DONE, 0);
         return;
      end
      if (q.command != CMD_SEG) begin
         push_done(KIND_DONE, 0);
         return;
      end
      for (int k = 0; k < NSES; k++)
         if (!hit && t_state[k] != ST_CLOSED && t_lport[k] == q.dst_port &&
             t_rport[k] == q.src_port && t_rip[k] == q.src_ip) begin
            hit = 1'b1;
            s = k;
         end
      // fall back to a listener, then reopen one on that port
      for (int k = 0; k < NSES; k++)
         if (!hit && t_state[k] == ST_LISTEN && t_lport[k] == q.dst_port) begin
            hit = 1'b1;
            s = k;
            t_rport[k] = q.src_port;
            t_rip[k] = q.src_ip;
            void'(take_listener(t_lport[k]));
         end
      if (!hit) begin
         push_done(KIND_NONE, 0);
         return;
      end
      t_tmo[s] = cfg_idle;
      if (q.flags_in & F_RST) begin
         t_state[s] = ST_CLOSED;
         push_done(KIND_DONE, s);
         return;
      end
      case (t_state[s])
         ST_LISTEN: begin
            if (q.flags_in == F_SYN) begin
               t_state[s] = ST_SYNRCV;
               t_sseq[s] = cfg_isn;
               t_rack[s] = q.seq_in + 1;
               push_segment(s, F_SYN | F_ACK);
            end
         end
         ST_SYNRCV: begin
            if (q.flags_in == F_ACK && t_sseq[s] == q.ack_in) t_state[s] = ST_ESTAB;
         end
         ST_ESTAB: begin
            if (q.flags_in & F_FIN) begin
               t_rack[s] = q.seq_in + q.data_len_in + 1;
               push_segment(s, F_ACK);
               push_segment(s, F_FIN | F_ACK);
               t_state[s] = ST_CLOSED;
            end else begin
               if (q.flags_in & F_ACK) t_sseq[s] = q.ack_in;
               if (q.seq_in != t_rack[s]) begin
                  dup = t_rack[s] - q.seq_in;
                  if (q.seq_in < t_rack[s] && {15'd0, dup} < {15'd0, len}) begin
                     off = off + dup[16:0];
                     len = len - dup[16:0];
                  end else begin
                     push_segment(s, F_ACK);
                     push_done(KIND_DONE, s);
                     return;
                  end
               end
               // clip to the receive buffer
               if (off > cfg_buf) off = cfg_buf;
               if (off + len > cfg_buf) len = cfg_buf - off;
               t_rack[s] = t_rack[s] + len;
               if (len != 0) begin
                  r = blank_rsp(KIND_DATA, s);
                  r.remote_ip = t_rip[s];
                  r.remote_port = t_rport[s];
                  r.local_port = t_lport[s];
                  r.data_offset = off[10:0];
                  r.data_len_out = len[10:0];
                  expected_rsps.push_back(r);
               end
            end
         end
         ST_LASTACK: begin
            if (q.seq_in == t_sseq[s] + 1) t_state[s] = ST_CLOSED;
            else push_segment(s, F_FIN | F_ACK);
         end
         default: t_state[s] = ST_CLOSED;
      endcase
      push_done(KIND_DONE, s);
   endfunction

   // driver: present queued beats, random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_session({req_command, req_src_ip, req_src_port, req_dst_port,
               req_seq_in, req_ack_in, req_flags_in, req_window_in,
               req_data_len_in, req_header_len});
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               {req_command, req_src_ip, req_src_port, req_dst_port, req_seq_in,
                req_ack_in, req_flags_in, req_window_in, req_data_len_in,
                req_header_len} <= pending_reqs.pop_front();
               if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted in cycles here
   initial begin
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   // monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result beat kind %0d", rsp_kind);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind exp %0h got %0h", e.kind, rsp_kind); errors++; end
               if (rsp_session !== e.session) begin
                  $error("session exp %0h got %0h", e.session, rsp_session); errors++; end
               if (rsp_flags_out !== e.flags_out) begin
                  $error("flags_out exp %0h got %0h", e.flags_out, rsp_flags_out);
                  errors++; end
               if (rsp_seq_out !== e.seq_out) begin
                  $error("seq_out exp %0h got %0h", e.seq_out, rsp_seq_out); errors++; end
               if (rsp_ack_out !== e.ack_out) begin
                  $error("ack_out exp %0h got %0h", e.ack_out, rsp_ack_out); errors++; end
               if (rsp_window_out !== e.window_out) begin
                  $error("window_out exp %0h got %0h", e.window_out, rsp_window_out);
                  errors++; end
               if (rsp_remote_ip !== e.remote_ip) begin
                  $error("remote_ip exp %0h got %0h", e.remote_ip, rsp_remote_ip);
                  errors++; end
               if (rsp_remote_port !== e.remote_port) begin
                  $error("remote_port exp %0h got %0h", e.remote_port, rsp_remote_port);
                  errors++; end
               if (rsp_local_port !== e.local_port) begin
                  $error("local_port exp %0h got %0h", e.local_port, rsp_local_port);
                  errors++; end
               if (rsp_data_offset !== e.data_offset) begin
                  $error("data_offset exp %0h got %0h", e.data_offset, rsp_data_offset);
                  errors++; end
               if (rsp_data_len_out !== e.data_len_out) begin
                  $error("data_len_out exp %0h got %0h", e.data_len_out, rsp_data_len_out);
                  errors++; end
               if (rsp_last_item !== e.last_item) begin
                  $error("last_item exp %0h got %0h", e.last_item, rsp_last_item);
                  errors++; end
            end
         end
         // receiver stall: long hold-off or random bursts
         if (rx_hold) begin
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 5) == 0) rsp_gap <= $urandom_range(1, 4);
         end
      end
   end

   function automatic req_type mk(logic [1:0] c, logic [31:0] ip, logic [15:0] rp,
         logic [15:0] lp, logic [31:0] sq, logic [31:0] ak, logic [5:0] f,
         logic [15:0] len, logic [6:0] hl);
      req_type q;
      q.command = c; q.src_ip = ip; q.src_port = rp; q.dst_port = lp;
      q.seq_in = sq; q.ack_in = ak; q.flags_in = f; q.window_in = 16'($urandom);
      q.data_len_in = len; q.header_len = hl;
      return q;
   endfunction

   task automatic wait_drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (2 * NSES + 10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_ISN: cfg_isn = val;
         REG_WIN: cfg_win = val[15:0];
         REG_IDLE: cfg_idle = val[7:0];
         REG_BUF: cfg_buf = val[10:0];
         default: ;
      endcase
   endtask

   // queue one well-formed connection with random content
   task automatic add_session_flow(logic [15:0] lp);
      logic [31:0] ip;
      logic [15:0] rp;
      logic [31:0] sq;
      logic [31:0] ak;
      logic [15:0] len;
      int n;
      ip = $urandom; rp = 16'($urandom); sq = $urandom;
      ak = cfg_isn + 1;
      pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq, 0, F_SYN, 0, 40));
      pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq + 1, ak, F_ACK, 0, 40));
      sq = sq + 1;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
         len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
         case ($urandom_range(0, 5))
            0: pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq - $urandom_range(0, 400),
                  ak, F_ACK | 6'd8, len, 7'($urandom_range(40, 120))));
            1: pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq + $urandom_range(1, 99),
                  ak, F_ACK, len, 7'($urandom_range(40, 120))));
            2: pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 40));
            default: begin
               pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq, ak,
                  ($urandom_range(0, 1) ? F_ACK : 6'd0) | 6'd8 | 6'd32, len,
                  7'($urandom_range(40, 120))));
               sq = sq + len;
            end
         endcase
      end
      case ($urandom_range(0, 3))
         0: pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq, ak, F_RST | F_ACK, 0, 40));
         1: ;
         default: pending_reqs.push_back(mk(CMD_SEG, ip, rp, lp, sq, ak, F_FIN | F_ACK,
               16'($urandom_range(0, 20)), 40));
      endcase
   endtask

   function automatic req_type noise();
      req_type q;
      logic [191:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(req_type)-1:0];
      if (q.header_len < 40 || q.header_len > 120)
         q.header_len = 7'($urandom_range(40, 120));
      if ($urandom_range(0, 1)) q.dst_port = 16'd80;
      return q;
   endfunction

   initial begin
      int cnt;
      cfg_isn = 32'd1234; cfg_win = 16'd8192; cfg_idle = 8'd10; cfg_buf = 11'd1500;
      for (int k = 0; k < NSES; k++) begin
         t_state[k] = ST_CLOSED; t_lport[k] = '0; t_rport[k] = '0; t_rip[k] = '0;
         t_sseq[k] = '0; t_rack[k] = '0; t_tmo[k] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: reset defaults, no session, handshake, data, extremes
      pending_reqs.push_back(mk(CMD_SEG, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 0, 0,
         F_SYN, 0, 120));
      pending_reqs.push_back(mk(CMD_BAD, 0, 0, 0, 0, 0, 0, 0, 40));
      pending_reqs.push_back(mk(CMD_OPEN, 0, 0, 16'd80, 0, 0, 0, 0, 40));
      pending_reqs.push_back(mk(CMD_OPEN, 0, 0, 16'hFFFF, 0, 0, 0, 0, 40));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80,
         32'hFFFFFFFF, 0, F_SYN, 0, 40));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80, 0, 32'd1235,
         F_ACK, 0, 40));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80, 0, 32'd1235,
         F_ACK, 16'hFFFF, 120));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80, 5, 32'd1235,
         F_ACK, 16'd2, 40));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80, 1400, 32'd1235,
         F_ACK, 16'd300, 40));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80, 1400, 32'd1235,
         F_ACK, 16'd10, 40));
      pending_reqs.push_back(mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 40));
      pending_reqs.push_back(mk(CMD_SEG, 32'h0A000001, 16'd1000, 16'd80, 0, 0,
         F_FIN | F_ACK, 16'd3, 40));
      for (int i = 0; i < 9; i++)
         pending_reqs.push_back(mk(CMD_OPEN, 0, 0, i[15:0], 0, 0, 0, 0, 40));
      wait_drain();
      // extreme settings; short timeout lets ticks close sessions
      write_reg(REG_ISN, 32'hFFFFFFFF);
      write_reg(REG_WIN, 32'h0000FFFF);
      write_reg(REG_IDLE, 32'd1);
      write_reg(REG_BUF, 32'd64);
      for (int i = 0; i < 4; i++) add_session_flow(16'd80);
      wait_drain();
      // pressure: long receiver hold-off while the sender keeps offering
      hold_go = 1'b1;
      for (int i = 0; i < 4; i++) add_session_flow(16'd80);
      wait_drain();
      cnt = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_reg(REG_ISN, $urandom);
         write_reg(REG_WIN, phase == 0 ? 32'd0 : $urandom);
         write_reg(REG_IDLE, phase == 1 ? 32'd255 : $urandom_range(1, 255));
         write_reg(REG_BUF, phase == 2 ? 32'd2047 : $urandom_range(64, 2047));
         if (phase == 3) quiet = 1'b1;
         pending_reqs.push_back(mk(CMD_OPEN, 0, 0, 16'd80, 0, 0, 0, 0, 40));
         while (cnt < (phase + 1) * 105) begin
            if ($urandom_range(0, 4) == 0) begin
               pending_reqs.push_back(noise());
               cnt++;
            end else begin
               add_session_flow(16'd80);
               cnt += 5;
            end
         end
         wait_drain();
      end
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== tcp_server_session_engine_core.f =====
+incdir+src
src/tsse_pkg.sv
src/tsse_front.sv
src/tsse_back.sv
src/tcp_server_session_engine_core.sv
src/tsse_checker.sv
sim/tcp_server_session_engine_core_tb.sv
